[hw/rtl/gshare_tournament_branch_predictor_macros.svh]
// Assertion macros for the branch predictor checker
`ifndef GSHARE_TOURNAMENT_BRANCH_PREDICTOR_MACROS_SVH
`define GSHARE_TOURNAMENT_BRANCH_PREDICTOR_MACROS_SVH

// same-cycle implication, disabled in reset
`define GTBP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gtbp assertion failed");

// next-cycle implication, disabled in reset
`define GTBP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gtbp assertion failed");

`endif

[hw/rtl/gtbp_pkg.sv]
// Shared types, constants and counter functions of the branch predictor
`timescale 1ns / 1ps
`default_nettype none

package gtbp_pkg;

  typedef enum logic [1:0] {
    MODE_STATIC = 2'd0,
    MODE_GSHARE = 2'd1,
    MODE_TOURNEY = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  localparam logic KIND_PREDICT = 1'b0;
  localparam logic KIND_TRAIN = 1'b1;

  localparam logic [1:0] CFG_MODE = 2'd0;
  localparam logic [1:0] CFG_GLOBAL_BITS = 2'd1;
  localparam logic [1:0] CFG_LOCAL_BITS = 2'd2;
  localparam logic [1:0] CFG_PC_BITS = 2'd3;

  localparam mode_t MODE_RESET = MODE_GSHARE;
  localparam logic [3:0] GLOBAL_BITS_RESET = 4'd13;
  localparam logic [3:0] LOCAL_BITS_RESET = 4'd10;
  localparam logic [3:0] PC_BITS_RESET = 4'd10;

  localparam logic [1:0] CTR_WEAK_NOT_TAKEN = 2'd1;
  localparam logic [1:0] CHOICE_WEAK_GLOBAL = 2'd2;
  localparam logic [1:0] CTR_MAX = 2'd3;
  localparam logic [1:0] CTR_MIN = 2'd0;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;
  localparam int CREDIT_W = FIFO_CNT_W + 1;

  function automatic logic [1:0] bump(input logic [1:0] c, input logic up);
    logic [1:0] r;
    r = c;
    if (up) begin
      if (c != CTR_MAX) r = c + 2'd1;
    end else begin
      if (c != CTR_MIN) r = c - 2'd1;
    end
    return r;
  endfunction

  function automatic logic says_taken(input logic [1:0] c);
    return c[1];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/gshare_tournament_branch_predictor.sv]
// Throughput: one request per cycle while in_ready is high; the local history read then the
// local counter read set the three-stage pipeline, with bypass registers covering back-to-back
// updates. A predict request is registered into stage B, then stage C, then the result FIFO.
// Reset: control and config go to defaults, then a clearing pass of 2**max(GLOBAL_BITS_MAX,
// LOCAL_BITS_MAX, PC_BITS_MAX) writes (8192 by default) fills all tables; in_ready stays low.
// Config writes wait for stages B and C to drain; requests hold off while a write is offered.
`timescale 1ns / 1ps
`default_nettype none

module gshare_tournament_branch_predictor
  import gtbp_pkg::*;
#(
  parameter int GLOBAL_BITS_MAX = 13,
  parameter int LOCAL_BITS_MAX = 10,
  parameter int PC_BITS_MAX = 10
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        kind,
  input  wire logic [31:0] branch_pc,
  input  wire logic        taken,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             predict_taken,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [3:0]  cfg_data
);

  localparam int GB = GLOBAL_BITS_MAX;
  localparam int LB = LOCAL_BITS_MAX;
  localparam int PB = PC_BITS_MAX;
  localparam int GL_MAX = (GB > LB) ? GB : LB;
  localparam int CLR_BITS = (GL_MAX > PB) ? GL_MAX : PB;

  // configuration
  mode_t      mode;
  logic [3:0] global_bits;
  logic [3:0] local_bits;
  logic [3:0] pc_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_RESET;
      global_bits <= GLOBAL_BITS_RESET;
      local_bits  <= LOCAL_BITS_RESET;
      pc_bits     <= PC_BITS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MODE:        mode <= mode_t'(cfg_data[1:0]);
        CFG_GLOBAL_BITS: global_bits <= cfg_data;
        CFG_LOCAL_BITS:  local_bits <= cfg_data;
        CFG_PC_BITS:     pc_bits <= cfg_data;
        default:         mode <= mode;
      endcase
    end
  end

  // effective widths and index masks
  logic [5:0]    gb_eff;
  logic [5:0]    lb_eff;
  logic [5:0]    pb_eff;
  logic [GB-1:0] gmask;
  logic [LB-1:0] lmask;
  logic [PB-1:0] pmask;

  assign gb_eff = (global_bits == 4'd0) ? 6'd1 :
                  ((6'(global_bits) > 6'(GB)) ? 6'(GB) : 6'(global_bits));
  assign lb_eff = (local_bits == 4'd0) ? 6'd1 :
                  ((6'(local_bits) > 6'(LB)) ? 6'(LB) : 6'(local_bits));
  assign pb_eff = (pc_bits == 4'd0) ? 6'd1 :
                  ((6'(pc_bits) > 6'(PB)) ? 6'(PB) : 6'(pc_bits));

  for (genvar gi = 0; gi < GB; gi++) begin : g_gmask
    assign gmask[gi] = (6'(gi) < gb_eff);
  end
  for (genvar li = 0; li < LB; li++) begin : g_lmask
    assign lmask[li] = (6'(li) < lb_eff);
  end
  for (genvar pi = 0; pi < PB; pi++) begin : g_pmask
    assign pmask[pi] = (6'(pi) < pb_eff);
  end

  // clearing pass
  logic                clr_busy;
  logic [CLR_BITS-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_cnt  <= '0;
    end else if (clr_busy) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == {CLR_BITS{1'b1}}) clr_busy <= 1'b0;
    end
  end

  // acceptance and result credit
  logic                  acc;
  logic [FIFO_CNT_W-1:0] fifo_count;
  logic [CREDIT_W-1:0]   inflight;
  logic                  b_valid;
  logic                  b_kind;
  logic                  c_valid;
  logic                  c_kind;

  assign inflight = CREDIT_W'(fifo_count)
                  + CREDIT_W'(b_valid && (b_kind == KIND_PREDICT))
                  + CREDIT_W'(c_valid && (c_kind == KIND_PREDICT));
  assign in_ready  = !clr_busy && !cfg_valid && (inflight < CREDIT_W'(FIFO_DEPTH));
  assign cfg_ready = !b_valid && !c_valid;
  assign acc       = in_valid && in_ready;

  // stage A: global history and table addresses
  logic          train_mode;
  logic [GB-1:0] ghist;
  logic [GB-1:0] gh_m;
  logic [GB-1:0] acc_gidx;
  logic [PB-1:0] acc_slot;

  assign train_mode = (mode == MODE_GSHARE) || (mode == MODE_TOURNEY);
  assign gh_m       = ghist & gmask;
  assign acc_gidx   = (mode == MODE_GSHARE) ? (gh_m ^ (branch_pc[GB-1:0] & gmask)) : gh_m;
  assign acc_slot   = branch_pc[PB-1:0] & pmask;

  always_ff @(posedge clk) begin
    if (rst) begin
      ghist <= '0;
    end else if (acc && (kind == KIND_TRAIN) && train_mode) begin
      ghist <= (ghist << 1) | GB'(taken);
    end
  end

  // stage B: local history with bypass, history update
  logic          b_taken;
  logic [GB-1:0] b_gidx;
  logic [PB-1:0] b_slot;
  logic [LB-1:0] lh_rdata;
  logic [LB-1:0] lh_full;
  logic [LB-1:0] lh_new;
  logic [LB-1:0] b_lidx;
  logic          lh_we;
  logic          lh_fwd_valid;
  logic [PB-1:0] lh_fwd_slot;
  logic [LB-1:0] lh_fwd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      b_kind  <= kind;
      b_taken <= taken;
      b_gidx  <= acc_gidx;
      b_slot  <= acc_slot;
    end
  end

  assign lh_full = (lh_fwd_valid && (lh_fwd_slot == b_slot)) ? lh_fwd_data : lh_rdata;
  assign lh_new  = (lh_full << 1) | LB'(b_taken);
  assign b_lidx  = lh_full & lmask;
  assign lh_we   = b_valid && (b_kind == KIND_TRAIN) && (mode == MODE_TOURNEY);

  always_ff @(posedge clk) begin
    if (rst) begin
      lh_fwd_valid <= 1'b0;
    end else begin
      lh_fwd_valid <= lh_we;
    end
  end

  always_ff @(posedge clk) begin
    lh_fwd_slot <= b_slot;
    lh_fwd_data <= lh_new;
  end

  gtbp_ram #(.W(LB), .AW(PB)) u_local_hist (
    .clk   (clk),
    .we    (clr_busy || lh_we),
    .waddr (clr_busy ? clr_cnt[PB-1:0] : b_slot),
    .wdata (clr_busy ? '0 : lh_new),
    .re    (acc),
    .raddr (acc_slot),
    .rdata (lh_rdata)
  );

  // stage C: counters with bypass, prediction and update
  logic          c_taken;
  logic [GB-1:0] c_gidx;
  logic [LB-1:0] c_lidx;
  logic [1:0]    gc_rdata;
  logic [1:0]    cc_rdata;
  logic [1:0]    lc_rdata;
  logic [1:0]    gc;
  logic [1:0]    cc;
  logic [1:0]    lc;
  logic [1:0]    gc_new;
  logic [1:0]    cc_new;
  logic [1:0]    lc_new;
  logic          g_right;
  logic          l_right;
  logic          c_train;
  logic          gc_we;
  logic          cc_we;
  logic          lc_we;
  logic          pred;
  logic          gc_fwd_valid;
  logic          cc_fwd_valid;
  logic          lc_fwd_valid;
  logic [GB-1:0] gc_fwd_addr;
  logic [GB-1:0] cc_fwd_addr;
  logic [LB-1:0] lc_fwd_addr;
  logic [1:0]    gc_fwd_data;
  logic [1:0]    cc_fwd_data;
  logic [1:0]    lc_fwd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid) begin
      c_kind  <= b_kind;
      c_taken <= b_taken;
      c_gidx  <= b_gidx;
      c_lidx  <= b_lidx;
    end
  end

  assign gc = (gc_fwd_valid && (gc_fwd_addr == c_gidx)) ? gc_fwd_data : gc_rdata;
  assign cc = (cc_fwd_valid && (cc_fwd_addr == c_gidx)) ? cc_fwd_data : cc_rdata;
  assign lc = (lc_fwd_valid && (lc_fwd_addr == c_lidx)) ? lc_fwd_data : lc_rdata;

  assign g_right = (says_taken(gc) == c_taken);
  assign l_right = (says_taken(lc) == c_taken);
  assign gc_new  = bump(gc, c_taken);
  assign lc_new  = bump(lc, c_taken);
  assign cc_new  = bump(cc, g_right);

  assign c_train = c_valid && (c_kind == KIND_TRAIN);
  assign gc_we   = c_train && train_mode;
  assign lc_we   = c_train && (mode == MODE_TOURNEY);
  assign cc_we   = lc_we && (g_right != l_right);

  always_comb begin
    unique case (mode)
      MODE_STATIC:  pred = 1'b1;
      MODE_GSHARE:  pred = says_taken(gc);
      MODE_TOURNEY: pred = says_taken(cc) ? says_taken(gc) : says_taken(lc);
      default:      pred = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gc_fwd_valid <= 1'b0;
      cc_fwd_valid <= 1'b0;
      lc_fwd_valid <= 1'b0;
    end else begin
      gc_fwd_valid <= gc_we;
      cc_fwd_valid <= cc_we;
      lc_fwd_valid <= lc_we;
    end
  end

  always_ff @(posedge clk) begin
    gc_fwd_addr <= c_gidx;
    cc_fwd_addr <= c_gidx;
    lc_fwd_addr <= c_lidx;
    gc_fwd_data <= gc_new;
    cc_fwd_data <= cc_new;
    lc_fwd_data <= lc_new;
  end

  gtbp_ram #(.W(2), .AW(GB)) u_global_ctr (
    .clk   (clk),
    .we    (clr_busy || gc_we),
    .waddr (clr_busy ? clr_cnt[GB-1:0] : c_gidx),
    .wdata (clr_busy ? CTR_WEAK_NOT_TAKEN : gc_new),
    .re    (b_valid),
    .raddr (b_gidx),
    .rdata (gc_rdata)
  );

  gtbp_ram #(.W(2), .AW(GB)) u_choice_ctr (
    .clk   (clk),
    .we    (clr_busy || cc_we),
    .waddr (clr_busy ? clr_cnt[GB-1:0] : c_gidx),
    .wdata (clr_busy ? CHOICE_WEAK_GLOBAL : cc_new),
    .re    (b_valid),
    .raddr (b_gidx),
    .rdata (cc_rdata)
  );

  gtbp_ram #(.W(2), .AW(LB)) u_local_ctr (
    .clk   (clk),
    .we    (clr_busy || lc_we),
    .waddr (clr_busy ? clr_cnt[LB-1:0] : c_lidx),
    .wdata (clr_busy ? CTR_WEAK_NOT_TAKEN : lc_new),
    .re    (b_valid),
    .raddr (b_lidx),
    .rdata (lc_rdata)
  );

  gtbp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (c_valid && (c_kind == KIND_PREDICT)),
    .push_data (pred),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (predict_taken),
    .count     (fifo_count)
  );

endmodule

`default_nettype wire

[hw/rtl/gtbp_ram.sv]
// Single-port-write, single-port-read table memory with registered read data
`timescale 1ns / 1ps
`default_nettype none

module gtbp_ram #(
  parameter int W = 2,
  parameter int AW = 10
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/gtbp_out_fifo.sv]
// Result queue between the predictor pipeline and the output channel
`timescale 1ns / 1ps
`default_nettype none

module gtbp_out_fifo
  import gtbp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire logic                  push_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_data,
  output logic      [FIFO_CNT_W-1:0] count
);

  logic                  slots [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic                  pop;

  assign out_valid = (count != '0);
  assign out_data  = slots[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      priority if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/gtbp_checker.sv]
// Port-level checker for the branch predictor, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "gshare_tournament_branch_predictor_macros.svh"

module gtbp_checker
  import gtbp_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic kind,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic predict_taken
);

  logic pred_req;
  assign pred_req = in_valid && in_ready && (kind == KIND_PREDICT);

  `GTBP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(predict_taken))
  `GTBP_ASSERT_IMP(a_clear_after_reset, $fell(rst), !in_ready)
  `GTBP_ASSERT_IMP(a_pred_latency, pred_req, ##3 out_valid)
  `GTBP_ASSERT_IMP(a_no_spurious_result, $rose(out_valid), $past(pred_req, 3))

endmodule

bind gshare_tournament_branch_predictor gtbp_checker u_gtbp_checker (.*);

`default_nettype wire

[test/tb_gshare_tournament_branch_predictor.sv]
// Self-checking testbench for the gshare and tournament branch predictor
`timescale 1ns / 1ps

module tb_gshare_tournament_branch_predictor;
  import gtbp_pkg::*;

  localparam int G_MAX = 13;
  localparam int L_MAX = 10;
  localparam int P_MAX = 10;
  localparam int ITEM_TARGET = 1650;
  localparam int SETTLE_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 50000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        kind = KIND_PREDICT;
  logic [31:0] branch_pc = '0;
  logic        taken = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        predict_taken;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_MODE;
  logic [3:0]  cfg_data = '0;

  logic [1:0]       glob_ctr [1 << G_MAX];
  logic [1:0]       choice_ctr [1 << G_MAX];
  logic [L_MAX-1:0] loc_hist [1 << P_MAX];
  logic [1:0]       loc_ctr [1 << L_MAX];
  logic [G_MAX-1:0] glob_hist;
  mode_t            cur_mode;
  logic [3:0]       g_bits;
  logic [3:0]       l_bits;
  logic [3:0]       p_bits;

  logic pending_dirs [$];
  int   errors = 0;
  int   items_sent = 0;
  int   dirs_checked = 0;
  int   reg_writes = 0;
  int   idle_cycles = 0;
  int   stall_left = 0;
  bit   quiet = 1'b0;

  gshare_tournament_branch_predictor i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .branch_pc     (branch_pc),
    .taken         (taken),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .predict_taken (predict_taken),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic logic [1:0] saturate_step(logic [1:0] c, logic up);
    if (up) return (c == 2'd3) ? c : c + 2'd1;
    return (c == 2'd0) ? c : c - 2'd1;
  endfunction

  function automatic logic leans_taken(logic [1:0] c);
    return c >= 2'd2;
  endfunction

  function automatic logic [31:0] width_to_mask(logic [3:0] bits, int max_bits);
    int b;
    b = bits;
    if (b < 1) b = 1;
    if (b > max_bits) b = max_bits;
    return (32'd1 << b) - 32'd1;
  endfunction

  task automatic predict_or_train(logic k, logic [31:0] pc, logic t);
    logic [31:0] gm, lm, pm, gh, gi, slot, lh;
    logic        dir, g_right, l_right;
    gm = width_to_mask(g_bits, G_MAX);
    lm = width_to_mask(l_bits, L_MAX);
    pm = width_to_mask(p_bits, P_MAX);
    gh = {19'd0, glob_hist} & gm;
    gi = (gh ^ pc) & gm;
    slot = pc & pm;
    lh = {22'd0, loc_hist[slot]} & lm;
    if (k == KIND_PREDICT) begin
      case (cur_mode)
        MODE_STATIC: dir = 1'b1;
        MODE_GSHARE: dir = leans_taken(glob_ctr[gi]);
        MODE_TOURNEY: begin
          if (leans_taken(choice_ctr[gh])) dir = leans_taken(glob_ctr[gh]);
          else dir = leans_taken(loc_ctr[lh]);
        end
        default: dir = 1'b0;
      endcase
      pending_dirs.push_back(dir);
    end else if (cur_mode == MODE_GSHARE) begin
      glob_ctr[gi] = saturate_step(glob_ctr[gi], t);
      glob_hist = {glob_hist[G_MAX-2:0], t};
    end else if (cur_mode == MODE_TOURNEY) begin
      g_right = leans_taken(glob_ctr[gh]) == t;
      l_right = leans_taken(loc_ctr[lh]) == t;
      if (g_right && !l_right) choice_ctr[gh] = saturate_step(choice_ctr[gh], 1'b1);
      else if (l_right && !g_right) choice_ctr[gh] = saturate_step(choice_ctr[gh], 1'b0);
      glob_ctr[gh] = saturate_step(glob_ctr[gh], t);
      loc_ctr[lh] = saturate_step(loc_ctr[lh], t);
      glob_hist = {glob_hist[G_MAX-2:0], t};
      loc_hist[slot] = {loc_hist[slot][L_MAX-2:0], t};
    end
  endtask

  task automatic send(logic k, logic [31:0] pc, logic t);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid = 1'b1;
    kind = k;
    branch_pc = pc;
    taken = t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_or_train(k, pc, t);
    items_sent++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [3:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MODE:        cur_mode = mode_t'(val[1:0]);
      CFG_GLOBAL_BITS: g_bits = val;
      CFG_LOCAL_BITS:  l_bits = val;
      default:         p_bits = val;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // hold off until every prediction is back and trailing updates have retired
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_dirs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_gshare_defaults();
    send(KIND_PREDICT, 32'h0000_0000, 1'b0);
    send(KIND_PREDICT, 32'hFFFF_FFFF, 1'b1);
    send(KIND_TRAIN, 32'h0000_0000, 1'b1);
    send(KIND_TRAIN, 32'h0000_0000, 1'b1);
    send(KIND_PREDICT, 32'h0000_0000, 1'b0);
    send(KIND_TRAIN, 32'hFFFF_FFFF, 1'b0);
    send(KIND_PREDICT, 32'hFFFF_FFFF, 1'b0);
  endtask

  task automatic test_static_mode();
    settle();
    write_reg(CFG_MODE, {2'b00, MODE_STATIC});
    send(KIND_PREDICT, 32'hA5A5_A5A5, 1'b0);
    send(KIND_TRAIN, 32'h5A5A_5A5A, 1'b0);
    send(KIND_TRAIN, 32'h5A5A_5A5A, 1'b1);
    send(KIND_PREDICT, 32'h5A5A_5A5A, 1'b1);
  endtask

  task automatic test_unused_mode();
    settle();
    write_reg(CFG_MODE, {2'b00, MODE_UNUSED});
    send(KIND_PREDICT, 32'h0000_0000, 1'b1);
    send(KIND_TRAIN, 32'h0000_0000, 1'b1);
    send(KIND_PREDICT, 32'hFFFF_FFFF, 1'b0);
  endtask

  task automatic test_width_extremes();
    settle();
    write_reg(CFG_MODE, {2'b00, MODE_TOURNEY});
    write_reg(CFG_GLOBAL_BITS, 4'd0);
    write_reg(CFG_LOCAL_BITS, 4'd15);
    write_reg(CFG_PC_BITS, 4'd0);
    send(KIND_TRAIN, 32'hFFFF_FFFF, 1'b1);
    send(KIND_TRAIN, 32'hFFFF_FFFF, 1'b1);
    send(KIND_PREDICT, 32'hFFFF_FFFF, 1'b0);
    send(KIND_PREDICT, 32'h0000_0000, 1'b0);
    settle();
    write_reg(CFG_GLOBAL_BITS, 4'd15);
    write_reg(CFG_LOCAL_BITS, 4'd0);
    write_reg(CFG_PC_BITS, 4'd15);
    send(KIND_TRAIN, 32'h0000_03FF, 1'b0);
    send(KIND_TRAIN, 32'h0000_03FF, 1'b0);
    send(KIND_PREDICT, 32'h0000_03FF, 1'b1);
    send(KIND_PREDICT, 32'hFFFF_FC00, 1'b0);
  endtask

  function automatic logic [3:0] pick_width(int max_bits);
    case ($urandom_range(0, 5))
      0: return 4'd0;
      1: return 4'd1;
      2: return 4'(max_bits);
      3: return 4'($urandom_range(max_bits + 1, 15));
      default: return 4'($urandom_range(1, max_bits));
    endcase
  endfunction

  // loops of predict then train per branch, with some stray requests mixed in
  task automatic test_random_traffic();
    logic [31:0] pcs [4];
    int          period [4];
    int          trip [4];
    int          phase_end, i;
    logic        outcome;
    while (items_sent < ITEM_TARGET) begin
      if (ITEM_TARGET - items_sent <= 200) quiet = 1'b1;
      if (!quiet) begin
        settle();
        case ($urandom_range(0, 9))
          0:       write_reg(CFG_MODE, {2'b00, MODE_STATIC});
          1:       write_reg(CFG_MODE, {2'b00, MODE_UNUSED});
          2, 3, 4: write_reg(CFG_MODE, {2'b00, MODE_GSHARE});
          default: write_reg(CFG_MODE, {2'b00, MODE_TOURNEY});
        endcase
        write_reg(CFG_GLOBAL_BITS, pick_width(G_MAX));
        write_reg(CFG_LOCAL_BITS, pick_width(L_MAX));
        write_reg(CFG_PC_BITS, pick_width(P_MAX));
      end
      for (i = 0; i < 4; i++) begin
        pcs[i] = $urandom();
        if ($urandom_range(0, 1) == 1) pcs[i][9:0] = 10'($urandom_range(0, 7));
        period[i] = $urandom_range(1, 6);
        trip[i] = 0;
      end
      phase_end = items_sent + 140;
      while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
        i = $urandom_range(0, 3);
        if ($urandom_range(0, 7) == 0) begin
          send(1'($urandom_range(0, 1)), $urandom(), 1'($urandom_range(0, 1)));
        end else begin
          outcome = (trip[i] % period[i]) != period[i] - 1;
          if ($urandom_range(0, 15) == 0) outcome = ~outcome;
          send(KIND_PREDICT, pcs[i], 1'($urandom_range(0, 1)));
          send(KIND_TRAIN, pcs[i], outcome);
          trip[i]++;
        end
      end
    end
  endtask

  always @(negedge clk) begin
    if (quiet) begin
      out_ready = 1'b1;
    end else if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 7) == 0) begin
      out_ready = 1'b0;
      stall_left = $urandom_range(0, 8);
    end else begin
      out_ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_dirs.size() == 0) begin
        $display("%0t: unexpected prediction, expected none, actual %0b", $time,
                 predict_taken);
        errors++;
      end else begin
        if (predict_taken !== pending_dirs[0]) begin
          $display("%0t: predict_taken mismatch, expected %0b, actual %0b", $time,
                   pending_dirs[0], predict_taken);
          errors++;
        end
        void'(pending_dirs.pop_front());
        dirs_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    for (int n = 0; n < (1 << G_MAX); n++) begin
      glob_ctr[n] = CTR_WEAK_NOT_TAKEN;
      choice_ctr[n] = CHOICE_WEAK_GLOBAL;
    end
    for (int n = 0; n < (1 << P_MAX); n++) loc_hist[n] = '0;
    for (int n = 0; n < (1 << L_MAX); n++) loc_ctr[n] = CTR_WEAK_NOT_TAKEN;
    glob_hist = '0;
    cur_mode = MODE_RESET;
    g_bits = GLOBAL_BITS_RESET;
    l_bits = LOCAL_BITS_RESET;
    p_bits = PC_BITS_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_gshare_defaults();
    test_static_mode();
    test_unused_mode();
    test_width_extremes();
    test_random_traffic();
    settle();

    $display("Sent %0d requests and checked %0d predictions across %0d register writes,",
             items_sent, dirs_checked, reg_writes);
    $display("covering static, gshare, tournament and unused modes at clamped widths.");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[gshare_tournament_branch_predictor.f]
+incdir+hw/rtl
hw/rtl/gtbp_pkg.sv
hw/rtl/gtbp_ram.sv
hw/rtl/gtbp_out_fifo.sv
hw/rtl/gshare_tournament_branch_predictor.sv
hw/rtl/gtbp_checker.sv
test/tb_gshare_tournament_branch_predictor.sv
